// ===== rtl/lbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types, constants and arithmetic helpers for the skinning block.
// ----------------------------------------------------------------------------
package lbs_pkg;

   localparam int MAX_JOINTS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int MAT_WORDS  = 12;
   localparam int JOINT_W    = 5;
   localparam int MEM_DEPTH  = MAX_JOINTS * MAT_WORDS;
   localparam int ADDR_W     = $clog2(MEM_DEPTH);

   localparam logic [1:0] ACT_LOAD_CUR  = 2'd0;
   localparam logic [1:0] ACT_LOAD_BIND = 2'd1;
   localparam logic [1:0] ACT_TERM      = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MAC,
      ST_ROUND,
      ST_WEIGHT,
      ST_EMIT
   } state_type;

   localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         sat_add = s[64] ? S64_MIN : S64_MAX;
      end else begin
         sat_add = s[63:0];
      end
   endfunction

   // Round half up then arithmetic shift by FRAC_BITS.
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] x);
      logic signed [63:0] r;
      r = sat_add(x, 64'sd1 <<< (FRAC_BITS - 1));
      round_shift = r >>> FRAC_BITS;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) begin
         sat32 = 32'sh7FFFFFFF;
      end else if (x < -64'sd2147483648) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = x[31:0];
      end
   endfunction

endpackage

// ===== rtl/lbs_mat_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_mat_ram
// Matrix store for one matrix set, one write and one registered read port.
// ----------------------------------------------------------------------------
module lbs_mat_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [lbs_pkg::ADDR_W-1:0]  wr_addr,
   input  logic signed [31:0]          wr_data,
   input  logic [lbs_pkg::ADDR_W-1:0]  rd_addr,
   output logic signed [31:0]          rd_data
);

   logic signed [31:0] mem [lbs_pkg::MEM_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/linear_blend_skinning.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_blend_skinning
// Linear blend skinning engine: per-joint affine matrices, weighted sum.
// ----------------------------------------------------------------------------
// Usage: the req_ channel carries one transaction per item. Action 0 or 1
// writes one entry of a joint's current or bind matrix. Action 2 is a vertex
// term: the bind matrix is applied to the position, the current matrix to
// that result, and the weighted product is added to a three-row accumulator.
// The term marked last pushes the saturated sum on the rsp_ channel and
// clears the accumulator.
// Timing: a term walks both matrices through one shared multiplier, each
// matrix word in a read state and then a multiply-accumulate state, from the
// matrix memories. Each row reads four words and then rounds; the six rows
// are followed by the three weight products and the emit step. req_ready is
// low from the accepting edge until the term has passed its emit step, so
// the block takes no new transaction while a term is in progress.
// Loads and unused codes leave the block idle. The result sits in an output
// register; the block accepts the next transaction while it waits, and stalls
// only when a new result would overwrite one not yet taken.
// Reset clears the control state and the accumulator; the matrix memories
// hold no reset value and must be written before use.
// ----------------------------------------------------------------------------
module linear_blend_skinning (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [4:0]         req_joint,
   input  logic [3:0]         req_entry,
   input  logic signed [31:0] req_value,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [16:0]        req_weight,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z
);

   localparam int AW = lbs_pkg::ADDR_W;

   lbs_pkg::state_type state_ff, state_in;

   // Step counters: pass 0 = bind, 1 = current; row and column in the matrix.
   logic       pass_ff, pass_in;
   logic [1:0] row_ff, row_in;
   logic [1:0] col_ff, col_in;

   logic [AW-1:0] base_ff, base_in;
   logic          last_ff, last_in;
   logic [16:0]   weight_ff, weight_in;
   logic signed [31:0] vec_ff [3];   // operand vector of the current pass
   logic signed [31:0] res_ff [3];   // result vector of the current pass
   logic signed [63:0] sum_ff;
   logic signed [63:0] acc_ff [3];
   logic               rsp_valid_ff;
   logic signed [31:0] out_ff [3];

   logic          cur_we, bind_we;
   logic [AW-1:0] wr_addr, rd_addr;
   logic signed [31:0] cur_rd, bind_rd, mat_word;
   logic [AW+3:0] lin_addr;

   logic accept;
   logic [1:0] act;
   logic load_ok;
   logic emit_fire;

   assign accept = req_valid && req_ready;
   assign act    = req_action;
   assign lin_addr = (AW + 4)'(req_joint) * (AW + 4)'(lbs_pkg::MAT_WORDS)
                     + (AW + 4)'(req_entry);
   assign load_ok = (32'(req_joint) < lbs_pkg::MAX_JOINTS)
                    && (req_entry < 4'(lbs_pkg::MAT_WORDS));
   assign wr_addr = lin_addr[AW-1:0];
   assign cur_we  = accept && act == lbs_pkg::ACT_LOAD_CUR && load_ok;
   assign bind_we = accept && act == lbs_pkg::ACT_LOAD_BIND && load_ok;
   assign rd_addr = base_ff + AW'(row_ff) * AW'(4) + AW'(col_ff);
   assign mat_word = pass_ff ? cur_rd : bind_rd;

   lbs_mat_ram u_cur (
      .clock(clock), .wr_en(cur_we), .wr_addr(wr_addr), .wr_data(req_value),
      .rd_addr(rd_addr), .rd_data(cur_rd)
   );
   lbs_mat_ram u_bind (
      .clock(clock), .wr_en(bind_we), .wr_addr(wr_addr), .wr_data(req_value),
      .rd_addr(rd_addr), .rd_data(bind_rd)
   );

   assign req_ready = state_ff == lbs_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_out_z = out_ff[2];

   // A last term hands its sum to the output register once that is free.
   assign emit_fire = state_ff == lbs_pkg::ST_EMIT && last_ff
                      && (!rsp_valid_ff || rsp_ready);

   // Next-state logic. Each row starts with the translation word (column 3)
   // so that the products are added against it in column order, 0 to 2.
   always_comb begin
      state_in    = state_ff;
      pass_in     = pass_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      base_in     = base_ff;
      last_in     = last_ff;
      weight_in   = weight_ff;
      unique case (state_ff)
         lbs_pkg::ST_IDLE: begin
            if (accept && act == lbs_pkg::ACT_TERM) begin
               base_in   = AW'(req_joint) * AW'(lbs_pkg::MAT_WORDS);
               last_in   = req_last;
               weight_in = req_weight;
               pass_in   = 1'b0;
               row_in    = 2'd0;
               col_in    = 2'd3;
               state_in  = (32'(req_joint) < lbs_pkg::MAX_JOINTS)
                           ? lbs_pkg::ST_READ : lbs_pkg::ST_EMIT;
            end
         end
         lbs_pkg::ST_READ: begin
            state_in = lbs_pkg::ST_MAC;
         end
         lbs_pkg::ST_MAC: begin
            if (col_ff == 2'd2) begin
               state_in = lbs_pkg::ST_ROUND;
            end else begin
               col_in   = col_ff + 2'd1;
               state_in = lbs_pkg::ST_READ;
            end
         end
         lbs_pkg::ST_ROUND: begin
            col_in = 2'd3;
            if (row_ff == 2'd2) begin
               row_in = 2'd0;
               if (pass_ff) begin
                  state_in = lbs_pkg::ST_WEIGHT;
               end else begin
                  pass_in  = 1'b1;
                  state_in = lbs_pkg::ST_READ;
               end
            end else begin
               row_in   = row_ff + 2'd1;
               state_in = lbs_pkg::ST_READ;
            end
         end
         lbs_pkg::ST_WEIGHT: begin
            if (row_ff == 2'd2) begin
               row_in   = 2'd0;
               state_in = lbs_pkg::ST_EMIT;
            end else begin
               row_in = row_ff + 2'd1;
            end
         end
         lbs_pkg::ST_EMIT: begin
            if (!last_ff || !rsp_valid_ff || rsp_ready) begin
               state_in = lbs_pkg::ST_IDLE;
            end
         end
         default: state_in = lbs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lbs_pkg::ST_IDLE;
         pass_ff     <= 1'b0;
         row_ff      <= 2'd0;
         col_ff      <= 2'd0;
         last_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pass_ff     <= pass_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         last_ff     <= last_in;
      end
   end

   // Datapath: one 32x32 multiply per cycle, accumulated with saturation.
   logic signed [63:0] prod;
   logic signed [31:0] mul_b;
   logic signed [31:0] mul_a;
   logic signed [63:0] rounded;

   always_comb begin
      mul_a = mat_word;
      mul_b = vec_ff[col_ff];
      if (state_ff == lbs_pkg::ST_WEIGHT) begin
         mul_a = res_ff[row_ff];
         mul_b = 32'(weight_ff);
      end
      prod    = 64'(mul_a) * 64'(mul_b);
      rounded = lbs_pkg::round_shift(sum_ff);
   end

   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      weight_ff <= weight_in;
      if (accept && act == lbs_pkg::ACT_TERM) begin
         vec_ff[0] <= req_pos_x;
         vec_ff[1] <= req_pos_y;
         vec_ff[2] <= req_pos_z;
         sum_ff    <= '0;
      end
      if (state_ff == lbs_pkg::ST_MAC) begin
         if (col_ff == 2'd3) begin
            sum_ff <= lbs_pkg::sat_add(sum_ff, 64'(mat_word) <<< lbs_pkg::FRAC_BITS);
         end else begin
            sum_ff <= lbs_pkg::sat_add(sum_ff, prod);
         end
      end
      if (state_ff == lbs_pkg::ST_ROUND) begin
         res_ff[row_ff] <= lbs_pkg::sat32(rounded);
         sum_ff <= '0;
         if (row_ff == 2'd2 && !pass_ff) begin
            vec_ff[0] <= res_ff[0];
            vec_ff[1] <= res_ff[1];
            vec_ff[2] <= lbs_pkg::sat32(rounded);
         end
      end
   end

   // Accumulator and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff[0]    <= '0;
         acc_ff[1]    <= '0;
         acc_ff[2]    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == lbs_pkg::ST_WEIGHT) begin
            acc_ff[row_ff] <= lbs_pkg::sat_add(acc_ff[row_ff],
                                               lbs_pkg::round_shift(prod));
         end
         if (emit_fire) begin
            out_ff[0]    <= lbs_pkg::sat32(acc_ff[0]);
            out_ff[1]    <= lbs_pkg::sat32(acc_ff[1]);
            out_ff[2]    <= lbs_pkg::sat32(acc_ff[2]);
            acc_ff[0]    <= '0;
            acc_ff[1]    <= '0;
            acc_ff[2]    <= '0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== rtl/lbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_checker
// Port-level checks on the skinning block, bound to the top level.
// ----------------------------------------------------------------------------
module lbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_action,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_out_x
);

   // A result stays until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x))
      else $error("result dropped or changed while stalled");

   // A load never produces a result on its own.
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action != lbs_pkg::ACT_TERM && !rsp_valid
      |=> !rsp_valid)
      else $error("load produced a result");

   // A term never completes in the cycle after it is accepted.
   a_term_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == lbs_pkg::ACT_TERM |=> !req_ready)
      else $error("term finished too early");

   // After reset no result is pending.
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind linear_blend_skinning lbs_checker u_lbs_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_action(req_action), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_out_x(rsp_out_x)
);
